FILE: hw/rtl/uctc_pkg.sv
// uctc_pkg: shared types and constants of the commanded time clock.
// No dependencies; used by every other file of the block but uctc_ifs.
package uctc_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam logic [7:0] TickDivideReset = 8'd2;

  localparam logic [7:0] ChBang = 8'h21;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero = 8'h30;

  localparam logic [3:0] MsgLen = 4'd10;
  localparam logic [3:0] WrongLen = 4'd15;

  typedef enum logic [1:0] {
    MODE_BYTE  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_READY = 2'd2
  } mode_t;

  // SINGLE: one char; CRLF: char then CR LF; WRONG: char then error text
  typedef enum logic [1:0] {
    REPLY_SINGLE = 2'd0,
    REPLY_CRLF   = 2'd1,
    REPLY_WRONG  = 2'd2
  } reply_kind_t;

  typedef struct packed {
    reply_kind_t kind;
    logic [7:0]  ch;
  } reply_t;

  typedef struct packed {
    logic   valid;
    reply_t data;
  } reply_push_t;

  function automatic logic [7:0] wrong_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:  c = 8'h57;
      4'd1:  c = 8'h72;
      4'd2:  c = 8'h6F;
      4'd3:  c = 8'h6E;
      4'd4:  c = 8'h67;
      4'd5:  c = 8'h20;
      4'd6:  c = 8'h43;
      4'd7:  c = 8'h6F;
      4'd8:  c = 8'h6D;
      4'd9:  c = 8'h6D;
      4'd10: c = 8'h61;
      4'd11: c = 8'h6E;
      4'd12: c = 8'h64;
      4'd13: c = ChCr;
      default: c = ChLf;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/uctc_ifs.sv
// uctc_ifs: valid/ready channel interfaces of the commanded time clock.
// Depends on nothing.
interface uctc_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;
  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface uctc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_char;
  logic       last;
  modport source (output valid, output tx_char, output last, input ready);
  modport sink (input valid, input tx_char, input last, output ready);
endinterface

interface uctc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/uctc_front.sv
// uctc_front: accepts events, keeps command, tick and time state, and
// pushes one reply descriptor per event that produces characters.
// Depends on uctc_pkg and uctc_ifs.
module uctc_front
  import uctc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  uctc_event_if.sink   events,
  uctc_cfg_if.sink     cfg,
  output reply_push_t  push,
  input  logic         push_ready
);

  logic [7:0] tick_divide;
  logic       display_on, display_on_next;
  logic       pending, pending_next;
  logic [8:0] tick_count, tick_count_next;
  logic [5:0] seconds, seconds_next;
  logic [5:0] minutes, minutes_next;
  logic [4:0] hours, hours_next;
  logic [3:0] send_pos, send_pos_next;
  logic [2:0] cmd_len, cmd_len_next;
  logic       start_match, start_match_next;
  logic       stop_match, stop_match_next;

  logic       accept;
  logic       start_hit, stop_hit;
  logic [2:0] len_inc;
  logic [6:0] sec_inc, min_inc;
  logic [5:0] hr_inc;

  function automatic logic [7:0] start_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = 8'h53;
      3'd1: c = 8'h74;
      3'd2: c = 8'h61;
      3'd3: c = 8'h72;
      3'd4: c = 8'h74;
      default: c = ChBang;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] stop_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = 8'h53;
      3'd1: c = 8'h74;
      3'd2: c = 8'h6F;
      3'd3: c = 8'h70;
      default: c = ChBang;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] tens(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else t = 3'd0;
    return t;
  endfunction

  function automatic logic [7:0] tens_char(input logic [5:0] v);
    return ChZero + {5'd0, tens(v)};
  endfunction

  function automatic logic [7:0] ones_char(input logic [5:0] v);
    logic [5:0] r;
    r = v - ({3'd0, tens(v)} * 6'd10);
    return ChZero + {2'd0, r};
  endfunction

  function automatic logic [7:0] msg_char(input logic [3:0] pos, input logic [4:0] hh,
                                          input logic [5:0] mm, input logic [5:0] ss);
    logic [7:0] c;
    case (pos)
      4'd1: c = tens_char({1'b0, hh});
      4'd2: c = ones_char({1'b0, hh});
      4'd3: c = ChColon;
      4'd4: c = tens_char(mm);
      4'd5: c = ones_char(mm);
      4'd6: c = ChColon;
      4'd7: c = tens_char(ss);
      4'd8: c = ones_char(ss);
      default: c = ChLf;
    endcase
    return c;
  endfunction

  assign events.ready = push_ready;
  assign cfg.ready = 1'b1;
  assign accept = events.valid && events.ready;

  assign start_hit = start_match && (cmd_len < 3'd6) && (events.rx_byte == start_char(cmd_len));
  assign stop_hit = stop_match && (cmd_len < 3'd5) && (events.rx_byte == stop_char(cmd_len));
  assign len_inc = (cmd_len < 3'd7) ? cmd_len + 3'd1 : cmd_len;
  assign sec_inc = {1'b0, seconds} + 7'd1;
  assign min_inc = {1'b0, minutes} + 7'd1;
  assign hr_inc = {1'b0, hours} + 6'd1;

  always_comb begin
    display_on_next = display_on;
    pending_next = pending;
    tick_count_next = tick_count;
    seconds_next = seconds;
    minutes_next = minutes;
    hours_next = hours;
    send_pos_next = send_pos;
    cmd_len_next = cmd_len;
    start_match_next = start_match;
    stop_match_next = stop_match;
    push.valid = 1'b0;
    push.data.kind = REPLY_SINGLE;
    push.data.ch = events.rx_byte;
    if (accept) begin
      case (events.mode)
        MODE_BYTE: begin
          push.valid = 1'b1;
          if (events.rx_byte == ChBang) begin
            cmd_len_next = 3'd0;
            start_match_next = 1'b1;
            stop_match_next = 1'b1;
            if (start_hit && len_inc == 3'd6) begin
              display_on_next = 1'b1;
              push.data.kind = REPLY_CRLF;
            end else if (stop_hit && len_inc == 3'd5) begin
              display_on_next = 1'b0;
              send_pos_next = 4'd0;
              push.data.kind = REPLY_CRLF;
            end else begin
              push.data.kind = REPLY_WRONG;
            end
          end else begin
            cmd_len_next = len_inc;
            start_match_next = start_hit;
            stop_match_next = stop_hit;
          end
        end
        MODE_TICK: begin
          if (!pending) begin
            if (tick_count >= {1'b0, tick_divide}) begin
              tick_count_next = 9'd1;
              if (display_on) begin
                pending_next = 1'b1;
                if (sec_inc >= 7'd60) begin
                  seconds_next = 6'd0;
                  if (min_inc >= 7'd60) begin
                    minutes_next = 6'd0;
                    hours_next = (hr_inc >= 6'd24) ? 5'd0 : hr_inc[4:0];
                  end else begin
                    minutes_next = min_inc[5:0];
                  end
                end else begin
                  seconds_next = sec_inc[5:0];
                end
              end else begin
                seconds_next = 6'd0;
                minutes_next = 6'd0;
                hours_next = 5'd0;
              end
            end else begin
              tick_count_next = tick_count + 9'd1;
            end
          end
        end
        MODE_READY: begin
          if (display_on && pending) begin
            if (send_pos < MsgLen) begin
              push.valid = 1'b1;
              push.data.ch = msg_char(send_pos, hours, minutes, seconds);
              send_pos_next = send_pos + 4'd1;
            end else begin
              pending_next = 1'b0;
              send_pos_next = 4'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divide <= TickDivideReset;
      display_on <= 1'b0;
      pending <= 1'b0;
      tick_count <= 9'd0;
      seconds <= 6'd0;
      minutes <= 6'd0;
      hours <= 5'd0;
      send_pos <= 4'd0;
      cmd_len <= 3'd0;
      start_match <= 1'b1;
      stop_match <= 1'b1;
    end else begin
      if (cfg.valid) tick_divide <= cfg.data;
      display_on <= display_on_next;
      pending <= pending_next;
      tick_count <= tick_count_next;
      seconds <= seconds_next;
      minutes <= minutes_next;
      hours <= hours_next;
      send_pos <= send_pos_next;
      cmd_len <= cmd_len_next;
      start_match <= start_match_next;
      stop_match <= stop_match_next;
    end
  end

endmodule

FILE: hw/rtl/uctc_queue.sv
// uctc_queue: short FIFO of reply descriptors between front and back.
// Depends on uctc_pkg.
module uctc_queue
  import uctc_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  reply_push_t push,
  output logic        push_ready,
  output logic        pop_valid,
  output reply_t      pop_data,
  input  logic        pop_ready
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  reply_t         slots [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = slots[rd_ptr];
  assign do_push = push.valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop) rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

FILE: hw/rtl/uctc_back.sv
// uctc_back: expands one reply descriptor into its characters, one per cycle while chars.ready is high.
// Depends on uctc_pkg and uctc_ifs.
module uctc_back
  import uctc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         pop_valid,
  input  reply_t       pop_data,
  output logic         pop_ready,
  uctc_char_if.source  chars
);

  logic       busy;
  reply_t     cur;
  logic [3:0] idx;
  logic [3:0] end_idx;
  logic       done;

  always_comb begin
    case (cur.kind)
      REPLY_CRLF:  end_idx = 4'd2;
      REPLY_WRONG: end_idx = WrongLen;
      default:     end_idx = 4'd0;
    endcase
  end

  always_comb begin
    if (idx == 4'd0) chars.tx_char = cur.ch;
    else if (cur.kind == REPLY_WRONG) chars.tx_char = wrong_char(idx - 4'd1);
    else if (idx == 4'd1) chars.tx_char = ChCr;
    else chars.tx_char = ChLf;
  end

  assign done = (idx == end_idx);
  assign chars.valid = busy;
  assign chars.last = done;
  assign pop_ready = !busy || (chars.ready && done);

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) cur <= pop_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= 4'd0;
    end else if (pop_ready) begin
      busy <= pop_valid;
      idx <= 4'd0;
    end else if (chars.ready) begin
      idx <= idx + 4'd1;
    end
  end

endmodule

FILE: hw/rtl/uart_commanded_time_clock.sv
// uart_commanded_time_clock: top level of the serial-commanded time clock.
// Depends on uctc_pkg, uctc_ifs, uctc_front, uctc_queue and uctc_back.
//
// Events (received byte, timer tick, transmitter ready) enter on the events
// channel at one per cycle while the reply queue has room; every event, even
// one that makes no characters, waits while the queue is full. Characters
// leave on the chars channel at one per cycle while the sink is ready; an
// echo or a time character is one character, a recognized command three and
// a rejected one sixteen. The character serializer in the back end sets the
// output pace; the queue of QUEUE_DEPTH replies lets events keep arriving
// while a long reply drains. The cfg channel always accepts and sets the tick
// divider. No clearing pass after reset.
module uart_commanded_time_clock
  import uctc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  uctc_event_if.sink  events,
  uctc_cfg_if.sink    cfg,
  uctc_char_if.source chars
);

  reply_push_t push;
  logic        push_ready;
  logic        pop_valid;
  reply_t      pop_data;
  logic        pop_ready;

  uctc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .events     (events),
    .cfg        (cfg),
    .push       (push),
    .push_ready (push_ready)
  );

  uctc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  uctc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .chars     (chars)
  );

`ifndef SYNTHESIS
  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (events.valid && events.ready))
    else $error("reply pushed without an accepted item");

  a_pop_holds: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && !pop_ready) |=> pop_valid)
    else $error("queued reply lost while back end busy");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !chars.valid)
    else $error("output valid right after reset");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for uart_commanded_time_clock (echo, commands, HH:MM:SS).
// Depends on uctc_pkg, uctc_ifs and the block's RTL; nothing else.
module tb_top;
  import uctc_pkg::*;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    bit         hold;
  } event_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } tx_due_t;

  localparam logic [47:0] StartWord = "Start!";
  localparam logic [39:0] StopWord = "Stop!";
  localparam logic [103:0] WrongWord = "Wrong Command";

  logic clk;
  logic rst;

  uctc_event_if ev_ch ();
  uctc_cfg_if cfg_ch ();
  uctc_char_if out_ch ();

  uart_commanded_time_clock i_dut (
    .clk    (clk),
    .rst    (rst),
    .events (ev_ch),
    .cfg    (cfg_ch),
    .chars  (out_ch)
  );

  event_item_t events_todo[$];
  tx_due_t     chars_due[$];
  int          errors;
  int          items_made;
  int          div_now;
  bit          hold_next;
  bit          ev_busy;
  bit          ev_taken;
  bit          src_idle_en;
  bit          snk_idle_en;
  int          src_gap;
  int          snk_gap;

  // clock state mirror
  logic [7:0] div_model;
  bit         disp_on;
  bit         msg_pending;
  logic [8:0] tick_cnt;
  logic [5:0] sec;
  logic [5:0] mins;
  logic [4:0] hrs;
  logic [3:0] send_pos;
  logic [2:0] cmd_len;
  bit         start_ok;
  bit         stop_ok;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2500000;
    $display("** uart_commanded_time_clock: FAILED **");
    $finish;
  end

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH @%0t: %s got %02h want %02h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [7:0] time_char(logic [3:0] pos);
    case (pos)
      4'd0: return ChLf;
      4'd1: return ChZero + 8'(hrs / 5'd10);
      4'd2: return ChZero + 8'(hrs % 5'd10);
      4'd3: return ChColon;
      4'd4: return ChZero + 8'(mins / 6'd10);
      4'd5: return ChZero + 8'(mins % 6'd10);
      4'd6: return ChColon;
      4'd7: return ChZero + 8'(sec / 6'd10);
      4'd8: return ChZero + 8'(sec % 6'd10);
      default: return ChLf;
    endcase
  endfunction

  task automatic predict_reply(logic [1:0] m, logic [7:0] b);
    logic [7:0] txt[$];
    int len;
    if (m == MODE_BYTE) begin
      len = cmd_len;
      txt.push_back(b);
      if (len >= 6) start_ok = 0;
      else if (b != StartWord[8*(5-len) +: 8]) start_ok = 0;
      if (len >= 5) stop_ok = 0;
      else if (b != StopWord[8*(4-len) +: 8]) stop_ok = 0;
      if (cmd_len < 3'd7) cmd_len = cmd_len + 3'd1;
      if (b == ChBang) begin
        if (start_ok && cmd_len == 3'd6) begin
          disp_on = 1;
          txt.push_back(ChCr);
          txt.push_back(ChLf);
        end else if (stop_ok && cmd_len == 3'd5) begin
          disp_on = 0;
          send_pos = 0;
          txt.push_back(ChCr);
          txt.push_back(ChLf);
        end else begin
          for (int i = 0; i < 13; i++) txt.push_back(WrongWord[8*(12-i) +: 8]);
          txt.push_back(ChCr);
          txt.push_back(ChLf);
        end
        cmd_len = 0;
        start_ok = 1;
        stop_ok = 1;
      end
    end else if (m == MODE_TICK) begin
      if (!msg_pending) begin
        if (tick_cnt >= {1'b0, div_model}) begin
          tick_cnt = 0;
          if (disp_on) begin
            msg_pending = 1;
            sec = sec + 6'd1;
            if (sec >= 6'd60) begin
              sec = 0;
              mins = mins + 6'd1;
            end
            if (mins >= 6'd60) begin
              mins = 0;
              hrs = hrs + 5'd1;
            end
            if (hrs >= 5'd24) hrs = 0;
          end else begin
            sec = 0;
            mins = 0;
            hrs = 0;
          end
        end
        tick_cnt = tick_cnt + 9'd1;
      end
    end else if (m == MODE_READY) begin
      if (disp_on && msg_pending) begin
        if (send_pos < MsgLen) begin
          txt.push_back(time_char(send_pos));
          send_pos = send_pos + 4'd1;
        end else begin
          msg_pending = 0;
          send_pos = 0;
        end
      end
    end
    foreach (txt[i]) chars_due.push_back('{txt[i], i == txt.size() - 1});
  endtask

  // monitor: config mirror, prediction on accepted events, char check
  always @(posedge clk) begin
    tx_due_t want;
    if (rst) begin
      ev_taken = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) div_model = cfg_ch.data;
      if (ev_ch.valid && ev_ch.ready) predict_reply(ev_ch.mode, ev_ch.rx_byte);
      ev_taken = ev_ch.valid && ev_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (chars_due.size() == 0) begin
          report_mismatch("spurious tx_char", out_ch.tx_char, 8'h00);
        end else begin
          want = chars_due.pop_front();
          if (out_ch.tx_char !== want.ch) report_mismatch("tx_char", out_ch.tx_char, want.ch);
          if (out_ch.last !== want.last) report_mismatch("last", 8'(out_ch.last), 8'(want.last));
        end
      end
    end
  end

  // event driver
  always @(negedge clk) begin
    event_item_t nxt;
    if (!rst) begin
      if (ev_taken) ev_busy = 0;
      if (!ev_busy) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (events_todo.size() > 0 && !(events_todo[0].hold && chars_due.size() > 0)) begin
          nxt = events_todo.pop_front();
          ev_ch.mode <= nxt.mode;
          ev_ch.rx_byte <= nxt.rx_byte;
          ev_busy = 1;
          if (src_idle_en && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 15);
        end
      end
      ev_ch.valid <= ev_busy;
    end
  end

  // char sink with stall bursts
  always @(negedge clk) begin
    if (!rst) begin
      if (snk_gap > 0) begin
        snk_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (snk_idle_en && $urandom_range(0, 11) == 0) snk_gap = $urandom_range(1, 15);
      end
    end
  end

  task automatic push_item(logic [1:0] m, logic [7:0] b);
    events_todo.push_back('{m, b, hold_next});
    hold_next = 0;
    items_made++;
  endtask

  task automatic push_word(string s, int mut_pos);
    for (int i = 0; i < s.len(); i++)
      push_item(MODE_BYTE, (i == mut_pos) ? 8'($urandom) : 8'(s[i]));
  endtask

  task automatic push_command();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) push_word("Start!", -1);
    else if (r < 6) push_word("Stop!", -1);
    else if (r == 6) push_word("Start!", $urandom_range(0, 4));
    else if (r == 7) begin
      push_word(r[0] ? "Stop" : "Start", -1);
      push_word(($urandom_range(0, 1) == 1) ? "Stop!" : "x!", -1);
    end else begin
      repeat ($urandom_range(0, 9)) push_item(MODE_BYTE, 8'($urandom));
      push_item(MODE_BYTE, ChBang);
    end
  endtask

  task automatic push_second();
    int n;
    n = (div_now <= 8) ? div_now + 1 : $urandom_range(1, 8);
    repeat (n) push_item(MODE_TICK, 8'($urandom));
    repeat ($urandom_range(9, 12)) push_item(MODE_READY, 8'($urandom));
  endtask

  task automatic push_mix(int n);
    int first;
    int r;
    first = items_made;
    while (items_made - first < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) push_second();
      else if (r < 70) push_command();
      else if (r < 75) hold_next = 1;
      else push_item(2'($urandom_range(0, 3)), 8'($urandom));
    end
  endtask

  task automatic wait_quiet();
    while (events_todo.size() > 0 || ev_busy || chars_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_divider(logic [7:0] v);
    wait_quiet();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    div_now = v;
  endtask

  initial begin
    rst = 1'b1;
    ev_ch.valid = 1'b0;
    ev_ch.mode = MODE_BYTE;
    ev_ch.rx_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 8'h00;
    out_ch.ready = 1'b0;
    div_model = TickDivideReset;
    div_now = TickDivideReset;
    tick_cnt = 0;
    sec = 0;
    mins = 0;
    hrs = 0;
    send_pos = 0;
    cmd_len = 0;
    start_ok = 1;
    stop_ok = 1;
    src_idle_en = 1;
    snk_idle_en = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: ignored mode, ready while off, Start, divided tick,
    // tick while pending, partial message, Stop while pending, zero byte
    push_item(2'd3, 8'hFF);
    push_item(MODE_READY, 8'h00);
    push_word("Start!", -1);
    repeat (4) push_item(MODE_TICK, 8'h00);
    repeat (4) push_item(MODE_READY, 8'hFF);
    push_word("Stop!", -1);
    push_item(MODE_BYTE, 8'h00);
    push_item(MODE_BYTE, 8'hFF);
    push_item(MODE_BYTE, ChBang);
    push_item(MODE_READY, 8'h00);

    write_divider(8'd0);
    push_mix(50);

    write_divider(8'd255);
    src_idle_en = 1;
    snk_idle_en = 0;
    push_word("Start!", -1);
    repeat (12) push_item(MODE_READY, 8'($urandom));
    repeat (20) push_item(MODE_TICK, 8'($urandom));
    push_mix(20);

    write_divider(8'($urandom_range(1, 7)));
    src_idle_en = 0;
    snk_idle_en = 1;
    push_mix(50);

    write_divider(8'($urandom_range(0, 255)));
    src_idle_en = 1;
    push_mix(30);

    // clean run at full rate
    write_divider(8'd0);
    src_idle_en = 0;
    snk_idle_en = 0;
    push_word("Start!", -1);
    repeat (12) push_item(MODE_READY, 8'h00);
    repeat (5) begin
      push_item(MODE_TICK, 8'($urandom));
      repeat (11) push_item(MODE_READY, 8'($urandom));
    end

    wait_quiet();
    if (errors == 0) begin
      $display("** uart_commanded_time_clock: PASSED **");
    end else begin
      $display("** uart_commanded_time_clock: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/uctc_pkg.sv
hw/rtl/uctc_ifs.sv
hw/rtl/uctc_front.sv
hw/rtl/uctc_queue.sv
hw/rtl/uctc_back.sv
hw/rtl/uart_commanded_time_clock.sv
verif/tb_top.sv
